// File: rtl/core/kmp_pkg.sv
// shared types and constants of the kmp pattern matcher
// used by the controller, the datapath, the top level and the checker
`default_nettype none

package kmp_pkg;

    localparam int MAX_PATTERN = 2048;
    localparam int ADDR_W      = $clog2(MAX_PATTERN);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int POS_W       = 16;
    localparam int SYM_W       = 8;
    localparam int FUNC_W      = 2;
    localparam int OUT_W       = 32;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_TEXT   = 2'd3
    } kmp_func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FALL
    } kmp_state_t;

    typedef struct packed {
        logic load;
        logic follow;
        logic to_fall;
        logic finish;
        logic in_fall;
    } kmp_cmd_t;

    typedef struct packed {
        kmp_func_t func;
        logic      len_zero;
        logic      store_full;
        logic      advance;
        logic      k_zero;
        logic      hit_next;
    } kmp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/kmp_pattern_matcher_top.sv
// top level of the kmp pattern matcher: joins controller and datapath
// depends on kmp_pkg, kmp_ctrl and kmp_datapath
`default_nettype none

// Knuth-Morris-Pratt matcher for one byte pattern of up to 2048 bytes. Each
// input transfer carries a function in s_tuser (clear pattern, append pattern
// byte, start text, text byte) and a byte in s_tdata; every transfer yields
// exactly one result transfer with the match flag, the 1-based text position
// (saturating at 65535), the loaded pattern length and a flag for a pattern
// byte dropped on a full store. The failure table is built as pattern bytes
// arrive, and overlapping matches are all reported. An item is taken in IDLE
// and finished in EXEC, with a further EXEC step for every failure link followed
// and a FALL step when a text byte completes a match; links followed never
// outnumber earlier advances. These extra steps come from the single read port
// of the pattern and failure memories, one link per cycle. A finished result
// waits in an output register while the next item is taken in; that item then
// holds in its last step until the waiting result has left.
module kmp_pattern_matcher_top (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [kmp_pkg::SYM_W-1:0]  s_tdata,   // symbol
    input  wire logic [kmp_pkg::FUNC_W-1:0] s_tuser,   // func
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // matched, end_position[16], pattern_length[12], pattern_full, zero pad
    output logic [kmp_pkg::OUT_W-1:0]       m_tdata
);
    import kmp_pkg::*;

    kmp_cmd_t    cmd;
    kmp_status_t status;

    kmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kmp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_func   (s_tuser),
        .in_symbol (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// File: rtl/core/kmp_datapath.sv
// datapath of the kmp matcher: pattern and failure memories, prefix registers,
// text position and the result register; depends on kmp_pkg
`default_nettype none

module kmp_datapath (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [kmp_pkg::FUNC_W-1:0] in_func,
    input  wire logic [kmp_pkg::SYM_W-1:0]  in_symbol,
    input  wire kmp_pkg::kmp_cmd_t          cmd,
    output kmp_pkg::kmp_status_t            status,
    output logic [kmp_pkg::OUT_W-1:0]       out_data
);
    import kmp_pkg::*;

    logic [SYM_W-1:0]  pat_mem  [MAX_PATTERN];
    logic [ADDR_W-1:0] fail_mem [MAX_PATTERN];

    logic [SYM_W-1:0]  pat_rd_reg;
    logic [ADDR_W-1:0] fail_rd_reg;

    kmp_func_t         func_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic [LEN_W-1:0]  k_reg, k_next;

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] build_reg, build_next;
    logic [LEN_W-1:0]  match_reg, match_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [OUT_W-1:0]  out_reg, out_next;

    logic [LEN_W-1:0]  start_k;
    logic [LEN_W-1:0]  k_minus1;
    logic [LEN_W-1:0]  k_plus1;
    logic [LEN_W-1:0]  k_final;
    logic              hit;
    logic              full;
    logic              wr_en;
    kmp_func_t         in_func_e;

    assign in_func_e = kmp_func_t'(in_func);

    // text resumes from the saved prefix, a pattern byte from the build prefix
    always_comb begin
        if (in_func_e == FUNC_APPEND) begin
            start_k = {1'b0, build_reg};
        end else if (match_reg >= len_reg) begin
            start_k = '0;
        end else begin
            start_k = match_reg;
        end
    end

    // memories are addressed by the next prefix so read data tracks k_reg
    always_comb begin
        if (cmd.load) begin
            k_next = start_k;
        end else if (cmd.follow) begin
            k_next = {1'b0, fail_rd_reg};
        end else if (cmd.to_fall) begin
            k_next = len_reg;
        end else begin
            k_next = k_reg;
        end
    end

    assign k_minus1 = k_next - LEN_W'(1);
    assign k_plus1  = k_reg + LEN_W'(1);

    assign status.func       = func_reg;
    assign status.len_zero   = (len_reg == '0);
    assign status.store_full = (len_reg >= MAX_LEN);
    assign status.advance    = (pat_rd_reg == sym_reg) && (k_reg < len_reg);
    assign status.k_zero     = (k_reg == '0);
    assign status.hit_next   = (k_plus1 == len_reg);

    assign wr_en = cmd.finish && (func_reg == FUNC_APPEND) && !status.store_full;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pat_mem[len_reg[ADDR_W-1:0]]  <= sym_reg;
            fail_mem[len_reg[ADDR_W-1:0]] <= k_final[ADDR_W-1:0];
        end
        pat_rd_reg  <= pat_mem[k_next[ADDR_W-1:0]];
        fail_rd_reg <= fail_mem[k_minus1[ADDR_W-1:0]];
    end

    // prefix reached at the end of the walk
    always_comb begin
        hit = 1'b0;
        if (status.len_zero) begin
            k_final = '0;
        end else if (cmd.in_fall) begin
            k_final = {1'b0, fail_rd_reg};
            hit     = (func_reg == FUNC_TEXT);
        end else if (status.advance) begin
            k_final = k_plus1;
        end else begin
            k_final = '0;
        end
    end

    always_comb begin
        len_next   = len_reg;
        build_next = build_reg;
        match_next = match_reg;
        pos_next   = pos_reg;
        full       = 1'b0;
        unique case (func_reg)
            FUNC_CLEAR: begin
                len_next   = '0;
                build_next = '0;
                match_next = '0;
            end
            FUNC_APPEND: begin
                if (status.store_full) begin
                    full = 1'b1;
                end else begin
                    len_next   = len_reg + LEN_W'(1);
                    build_next = k_final[ADDR_W-1:0];
                end
            end
            FUNC_START: begin
                match_next = '0;
                pos_next   = '0;
            end
            FUNC_TEXT: begin
                match_next = k_final;
                if (pos_reg != '1) begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            default: begin
                len_next = len_reg;
            end
        endcase
    end

    assign out_next = {{(OUT_W - LEN_W - POS_W - 2){1'b0}}, full, len_next, pos_next, hit};
    assign out_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            build_reg <= '0;
            match_reg <= '0;
            pos_reg   <= '0;
        end else if (cmd.finish) begin
            len_reg   <= len_next;
            build_reg <= build_next;
            match_reg <= match_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        if (cmd.load) begin
            func_reg <= in_func_e;
            sym_reg  <= in_symbol;
        end
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/kmp_ctrl.sv
// controller of the kmp matcher: sequences accept, failure-link walk,
// fallback after a match and the result register handshake; depends on kmp_pkg
`default_nettype none

module kmp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire kmp_pkg::kmp_status_t status,
    output kmp_pkg::kmp_cmd_t         cmd
);
    import kmp_pkg::*;

    kmp_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       simple;
    logic       is_text;
    logic       exec_finish;
    logic       exec_fall;
    logic       exec_follow;

    assign out_free = !out_valid_reg || m_tready;
    assign is_text  = (status.func == FUNC_TEXT);

    // items that need no memory walk
    assign simple = (status.func == FUNC_CLEAR) || (status.func == FUNC_START)
                 || ((status.func == FUNC_APPEND) && status.store_full)
                 || status.len_zero;

    assign exec_fall   = !simple && status.advance && is_text && status.hit_next;
    assign exec_follow = !simple && !status.advance && !status.k_zero;
    assign exec_finish = simple
                      || (status.advance && !(is_text && status.hit_next))
                      || (!status.advance && status.k_zero);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fall) begin
                    state_next = ST_FALL;
                end else if (exec_finish && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FALL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_EXEC: begin
                cmd.follow  = exec_follow;
                cmd.to_fall = exec_fall;
                cmd.finish  = exec_finish && out_free;
            end
            ST_FALL: begin
                cmd.in_fall = 1'b1;
                cmd.finish  = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/kmp_checker.sv
// port-level checker for the kmp pattern matcher and its bind to the top level
// depends on kmp_pkg
`default_nettype none

module kmp_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [kmp_pkg::OUT_W-1:0]  m_tdata
);
    import kmp_pkg::*;

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // no result out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a match needs a loaded pattern
    a_match_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[28:17] != 12'd0)
        else $error("match reported with empty pattern");

    // a dropped byte only when the store is full, and never with a match
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[29] |-> m_tdata[28:17] == MAX_LEN && !m_tdata[0])
        else $error("pattern full flag with room in store");

    // an input transfer is taken only when no walk is in progress
    a_in_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back-to-back cycles");

endmodule

bind kmp_pattern_matcher_top kmp_checker u_kmp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: sim/kmp_match_checker.sv
// result checker for the kmp pattern matcher: watches both streams, predicts each result
// from its own copy of pattern, failure links and text state, and compares field by field
// depends on kmp_pkg
`timescale 1ns / 1ps

module kmp_match_checker (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic [kmp_pkg::SYM_W-1:0]  s_tdata,
    input  wire logic [kmp_pkg::FUNC_W-1:0] s_tuser,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [kmp_pkg::OUT_W-1:0]  m_tdata,
    output int                              fail_count,
    output int                              pending
);
    import kmp_pkg::*;

    // same bit order as m_tdata: hit in bit 0, full in bit 29
    typedef struct packed {
        logic             full;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] pos;
        logic             hit;
    } match_result_t;

    logic [SYM_W-1:0]  pat_mem  [0:MAX_PATTERN-1];
    logic [ADDR_W-1:0] link_mem [0:MAX_PATTERN-1];
    logic [LEN_W-1:0]  pat_len;
    logic [ADDR_W-1:0] build_k;
    logic [LEN_W-1:0]  text_k;
    logic [POS_W-1:0]  text_pos;

    match_result_t result_q[$];

    task automatic grow_pattern(input logic [SYM_W-1:0] c);
        logic [LEN_W-1:0] k;
        if (pat_len == '0) begin
            k = '0;
        end else begin
            k = LEN_W'(build_k);
            while (k != '0 && pat_mem[k[ADDR_W-1:0]] != c)
                k = LEN_W'(link_mem[k[ADDR_W-1:0] - 1'b1]);
            if (pat_mem[k[ADDR_W-1:0]] == c && k < pat_len)
                k = k + 1'b1;
        end
        link_mem[pat_len[ADDR_W-1:0]] = k[ADDR_W-1:0];
        build_k = k[ADDR_W-1:0];
        pat_mem[pat_len[ADDR_W-1:0]] = c;
        pat_len = pat_len + 1'b1;
    endtask

    task automatic scan_text(input logic [SYM_W-1:0] c, output logic hit);
        logic [LEN_W-1:0] k;
        hit = 1'b0;
        if (text_pos != {POS_W{1'b1}})
            text_pos = text_pos + 1'b1;
        if (pat_len == '0) begin
            text_k = '0;
        end else begin
            k = text_k;
            if (k >= pat_len)
                k = '0;
            while (k != '0 && pat_mem[k[ADDR_W-1:0]] != c)
                k = LEN_W'(link_mem[k[ADDR_W-1:0] - 1'b1]);
            if (pat_mem[k[ADDR_W-1:0]] == c)
                k = k + 1'b1;
            // full occurrence: fall back so overlapping matches are seen
            if (k == pat_len) begin
                hit = 1'b1;
                k = LEN_W'(link_mem[ADDR_W'(pat_len - 1'b1)]);
            end
            text_k = k;
        end
    endtask

    task automatic predict_item(input kmp_func_t f, input logic [SYM_W-1:0] c);
        match_result_t r;
        r = '0;
        case (f)
            FUNC_CLEAR: begin
                pat_len = '0;
                build_k = '0;
                text_k  = '0;
            end
            FUNC_APPEND: begin
                if (pat_len >= MAX_LEN)
                    r.full = 1'b1;
                else
                    grow_pattern(c);
            end
            FUNC_START: begin
                text_k   = '0;
                text_pos = '0;
            end
            default: scan_text(c, r.hit);
        endcase
        r.pos = text_pos;
        r.len = pat_len;
        result_q.insert(result_q.size(), r);
    endtask

    always @(posedge aclk) begin
        match_result_t want;
        match_result_t got;
        if (!aresetn) begin
            result_q.delete();
            pat_len    = '0;
            build_k    = '0;
            text_k     = '0;
            text_pos   = '0;
            fail_count = 0;
            pending    = 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_item(kmp_func_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) begin
                got = match_result_t'(m_tdata[$bits(match_result_t)-1:0]);
                if (result_q.size() == 0) begin
                    $error("result transfer with nothing expected: m_tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("matched mismatch: expected %0d, got %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.pos !== want.pos) begin
                        $error("end_position mismatch: expected %0d, got %0d",
                               want.pos, got.pos);
                        fail_count++;
                    end
                    if (got.len !== want.len) begin
                        $error("pattern_length mismatch: expected %0d, got %0d",
                               want.len, got.len);
                        fail_count++;
                    end
                    if (got.full !== want.full) begin
                        $error("pattern_full mismatch: expected %0d, got %0d",
                               want.full, got.full);
                        fail_count++;
                    end
                end
            end
            pending = result_q.size();
        end
    end

endmodule

// File: sim/kmp_pattern_matcher_top_test.sv
// testbench top for the kmp pattern matcher: clock, reset, stimulus and verdict
// depends on kmp_pkg, kmp_pattern_matcher_top and kmp_match_checker
`timescale 1ns / 1ps

module kmp_pattern_matcher_top_test;
    import kmp_pkg::*;

    localparam int  CYCLE_LIMIT  = 400_000;
    localparam int  RANDOM_ITEMS = 400;
    localparam int  LONG_HOLD    = 400;
    localparam int  DRAIN_TAIL   = 40;
    localparam int  FULL_TEXT    = 6;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [SYM_W-1:0]  s_tdata  = '0;
    logic [FUNC_W-1:0] s_tuser  = FUNC_CLEAR;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    int fail_count;
    int pending;
    int cycles     = 0;
    int item_count = 0;
    int burst_left = 0;
    bit hold_req   = 1'b0;

    // bytes of the pattern as loaded, used to plant occurrences in the text
    logic [SYM_W-1:0] pat_copy[$];

    always #5 aclk = ~aclk;

    kmp_pattern_matcher_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    kmp_match_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side stalls on runs of its own, with one long hold-off in the random phase
    initial begin : ready_gen
        int   run;
        logic rdy;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (LONG_HOLD) begin
                    @(posedge aclk);
                    m_tready <= 1'b0;
                end
            end
            case ($urandom_range(0, 5))
                0: begin
                    rdy = 1'b0;
                    run = $urandom_range(1, 6);
                end
                1: begin
                    rdy = 1'b1;
                    run = $urandom_range(20, 60);
                end
                default: begin
                    rdy = 1'($urandom_range(0, 1));
                    run = $urandom_range(1, 4);
                end
            endcase
            repeat (run) begin
                @(posedge aclk);
                m_tready <= rdy;
            end
        end
    end

    // called on a rising edge, returns on the edge of the transfer
    task automatic send_item(input kmp_func_t f, input logic [SYM_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0)
            burst_left--;
        item_count++;
        if (f == FUNC_CLEAR)
            pat_copy.delete();
        else if (f == FUNC_APPEND && pat_copy.size() < MAX_PATTERN)
            pat_copy.insert(pat_copy.size(), b);
    endtask

    // stop offering until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
    endtask

    task automatic send_byte(input logic [SYM_W-1:0] b);
        send_item(FUNC_TEXT, b);
    endtask

    // mostly clear, load a mostly short pattern over a small alphabet, start, then text with planted copies
    task automatic pattern_run();
        logic [SYM_W-1:0] alph [0:2];
        int n, plen, tlen, i, j, sz;
        n = $urandom_range(1, 3);
        for (i = 0; i < 3; i++)
            alph[i] = SYM_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
            send_item(FUNC_CLEAR, SYM_W'($urandom_range(0, 255)));
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (i = 0; i < plen; i++)
            send_item(FUNC_APPEND, alph[$urandom_range(0, n - 1)]);
        send_item(FUNC_START, SYM_W'($urandom_range(0, 255)));
        tlen = $urandom_range(4, 50);
        i = 0;
        while (i < tlen) begin
            sz = pat_copy.size();
            if ($urandom_range(0, 2) == 0 && sz > 0 && sz < 64) begin
                for (j = 0; j < sz; j++)
                    send_byte(pat_copy[j]);
                i += sz;
            end else begin
                if ($urandom_range(0, 9) == 0)
                    send_byte(SYM_W'($urandom_range(0, 255)));
                else
                    send_byte(alph[$urandom_range(0, n - 1)]);
                i++;
            end
        end
    endtask

    // text interrupted by pattern edits or restarts
    task automatic broken_run();
        logic [SYM_W-1:0] a;
        int i, cnt;
        a = SYM_W'($urandom_range(0, 255));
        send_item(FUNC_START, SYM_W'($urandom_range(0, 255)));
        cnt = $urandom_range(1, 12);
        for (i = 0; i < cnt; i++) begin
            case ($urandom_range(0, 7))
                0: send_item(FUNC_APPEND, a);
                1: send_item(FUNC_CLEAR, SYM_W'($urandom_range(0, 255)));
                2: send_item(FUNC_START, SYM_W'($urandom_range(0, 255)));
                default: send_byte(($urandom_range(0, 1) == 1) ? a : pat_copy.size() > 0 ?
                                   pat_copy[0] : a);
            endcase
        end
    endtask

    initial begin : stimulus
        int  i, sel, base;
        bit  hold_done, pause_done;
        logic [SYM_W-1:0] x, y;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pattern, extreme bytes, overlap, growth during text
        send_item(FUNC_CLEAR, 8'hFF);
        send_byte(8'h00);
        send_item(FUNC_APPEND, 8'h00);
        send_item(FUNC_APPEND, 8'hFF);
        send_item(FUNC_START, 8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_item(FUNC_CLEAR, 8'h00);
        send_item(FUNC_APPEND, 8'hAA);
        send_item(FUNC_APPEND, 8'hAA);
        send_byte(8'hAA);
        send_byte(8'hAA);
        send_byte(8'hAA);
        send_item(FUNC_APPEND, 8'hAA);
        send_byte(8'hAA);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_item(FUNC_START, 8'h00);
        send_byte(8'hAA);
        drain();

        // random phase
        base = item_count;
        while (item_count < base + RANDOM_ITEMS) begin
            if (!hold_done && item_count > base + 120) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && item_count > base + 280) begin
                drain();
                pause_done = 1'b1;
            end
            sel = $urandom_range(0, 9);
            if (sel == 7) begin
                for (i = $urandom_range(1, 10); i > 0; i--)
                    send_item(kmp_func_t'(FUNC_W'($urandom_range(0, 3))),
                              SYM_W'($urandom_range(0, 255)));
            end else if (sel == 8) begin
                broken_run();
            end else begin
                pattern_run();
            end
        end
        drain();

        // full store: longest pattern of one byte, two dropped appends, short text
        x = SYM_W'($urandom_range(0, 255));
        y = ~x;
        send_item(FUNC_CLEAR, x);
        for (i = 0; i < MAX_PATTERN; i++)
            send_item(FUNC_APPEND, x);
        send_item(FUNC_APPEND, x);
        send_item(FUNC_APPEND, y);
        send_item(FUNC_START, x);
        for (i = 0; i < FULL_TEXT; i++)
            send_byte(x);
        send_byte(y);
        send_byte(x);

        drain();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
